// ===== hdl/integer_to_ascii_formatter_defines.svh =====
// Assertion macros shared by the formatter modules
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define ITAF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ITAF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/itaf_pkg.sv =====
// Package: shared types and constants for the integer formatter
package itaf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PAD,
        ST_ALT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned MAX_RESULTS = 64;

    localparam logic [1:0] SEL_OCT = 2'd0;
    localparam logic [1:0] SEL_DEC = 2'd1;
    localparam logic [1:0] SEL_HEX = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture input word
        logic div_step; // one shift of the binary-to-BCD conversion
        logic push_dig; // push the lowest remaining digit
        logic push_pad; // push one pad/precision character
        logic alt_trim; // drop columns for the prefix
        logic push_x;   // push x/X
        logic push_0;   // push the prefix zero
        logic push_sgn; // push sign
        logic emit_adv; // advance output index
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;  // digits ready to be taken
        logic more_dig;  // digits remain after this one and room left
        logic skip_dig;  // no digits at all (zero, precision given)
        logic pad_more;  // a pad character still belongs
        logic alt_on;    // prefix requested
        logic x_room;    // hex selected (room for x is checked in the datapath)
        logic emit_last; // current output is the last one
    } sts_t;

endpackage

// ===== hdl/integer_to_ascii_formatter.sv =====
// Top level of the printf-style integer field formatter
// Each word in carries a 64-bit magnitude and its format flags; the block
// returns the formatted field one ASCII character per output word, left to
// right, with last_char on the final one (a field with no characters gives
// one word with empty_field set). A decimal value first passes through a
// shift-and-add-3 conversion to BCD; octal and hex digits come straight from
// the magnitude. After that an item pushes its digits (up to 20 decimal, 22
// octal, 16 hex), then its pad characters, then trims for the prefix, pushes
// prefix and sign, and sends one output word per cycle while out_stall is low.
// Digits, pad characters, prefix and sign together stop at the buffer
// capacity (BUF_LEN, at most 64).
// One item is in work at a time; in_stall stays high until its last word.
module integer_to_ascii_formatter #(
    parameter int unsigned BUF_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] magnitude,
    input  logic        is_negative,
    input  logic [1:0]  base_sel,
    input  logic [6:0]  min_digits,
    input  logic [6:0]  field_width,
    input  logic        zero_pad,
    input  logic        left_justify,
    input  logic        plus_sign,
    input  logic        space_sign,
    input  logic        alt_form,
    input  logic        upper_case,
    input  logic        precision_given,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_code,
    output logic        last_char,
    output logic        empty_field
);

    itaf_pkg::cmd_t cmd;
    itaf_pkg::sts_t sts;

    itaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    itaf_dp #(
        .BUF_LEN (BUF_LEN)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .magnitude       (magnitude),
        .is_negative     (is_negative),
        .base_sel        (base_sel),
        .min_digits      (min_digits),
        .field_width     (field_width),
        .zero_pad        (zero_pad),
        .left_justify    (left_justify),
        .plus_sign       (plus_sign),
        .space_sign      (space_sign),
        .alt_form        (alt_form),
        .upper_case      (upper_case),
        .precision_given (precision_given),
        .char_code       (char_code),
        .last_char       (last_char),
        .empty_field     (empty_field)
    );

endmodule

// ===== hdl/itaf_ctrl.sv =====
// Controller state machine for the integer formatter
`include "integer_to_ascii_formatter_defines.svh"

module itaf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  itaf_pkg::sts_t  sts,
    output itaf_pkg::cmd_t  cmd
);

    itaf_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itaf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = itaf_pkg::ST_DIV;
                end
            end
            itaf_pkg::ST_DIV:
            begin
                if (sts.skip_dig)
                begin
                    state_next = itaf_pkg::ST_PAD;
                end
                else if (sts.div_done && !sts.more_dig)
                begin
                    state_next = itaf_pkg::ST_PAD;
                end
            end
            itaf_pkg::ST_PAD:
            begin
                if (!sts.pad_more)
                begin
                    state_next = itaf_pkg::ST_ALT;
                end
            end
            itaf_pkg::ST_ALT:
            begin
                state_next = itaf_pkg::ST_SIGN;
            end
            itaf_pkg::ST_SIGN:
            begin
                state_next = itaf_pkg::ST_EMIT;
            end
            itaf_pkg::ST_EMIT:
            begin
                if (!out_stall && sts.emit_last)
                begin
                    state_next = itaf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itaf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            itaf_pkg::ST_DIV:
            begin
                if (!sts.skip_dig)
                begin
                    cmd.div_step = !sts.div_done;
                    cmd.push_dig = sts.div_done;
                end
            end
            itaf_pkg::ST_PAD:
            begin
                cmd.push_pad = sts.pad_more;
            end
            itaf_pkg::ST_ALT:
            begin
                cmd.alt_trim = sts.alt_on;
            end
            itaf_pkg::ST_SIGN:
            begin
                cmd.push_x   = sts.alt_on && sts.x_room;
                cmd.push_0   = sts.alt_on;
                cmd.push_sgn = 1'b1;
            end
            itaf_pkg::ST_EMIT:
            begin
                out_valid    = 1'b1;
                cmd.emit_adv = !out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ITAF_ASSERT_IMP(a_out_only_emit, clk, rst_n, out_valid, state_reg == itaf_pkg::ST_EMIT, "out_valid outside emit")
    `ITAF_ASSERT_IMP(a_no_accept_busy, clk, rst_n, !in_stall, state_reg == itaf_pkg::ST_IDLE, "input taken while busy")
    `ITAF_ASSERT_NXT(a_load_to_div, clk, rst_n, cmd.load, state_reg == itaf_pkg::ST_DIV, "load not followed by division")

endmodule

// ===== hdl/itaf_dp.sv =====
// Datapath: digit conversion, character buffer and output selection
`include "integer_to_ascii_formatter_defines.svh"

module itaf_dp #(
    parameter int unsigned BUF_LEN = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  itaf_pkg::cmd_t  cmd,
    output itaf_pkg::sts_t  sts,
    input  logic [63:0]     magnitude,
    input  logic            is_negative,
    input  logic [1:0]      base_sel,
    input  logic [6:0]      min_digits,
    input  logic [6:0]      field_width,
    input  logic            zero_pad,
    input  logic            left_justify,
    input  logic            plus_sign,
    input  logic            space_sign,
    input  logic            alt_form,
    input  logic            upper_case,
    input  logic            precision_given,
    output logic [7:0]      char_code,
    output logic            last_char,
    output logic            empty_field
);

    localparam int unsigned CAP = (BUF_LEN < itaf_pkg::MAX_RESULTS) ?
                                  BUF_LEN : itaf_pkg::MAX_RESULTS;
    localparam int unsigned LW  = $clog2(CAP + 1);
    localparam int unsigned AW  = $clog2(CAP);
    localparam logic [LW-1:0] CAP_L = LW'(CAP);
    localparam int unsigned BCD_DIGITS = 20;

    // Captured item
    logic [79:0] val_reg;
    logic [63:0] bin_reg;
    logic [6:0]  bit_reg;
    logic        zero_reg;
    logic        neg_reg, zp_reg, lj_reg, plus_reg, spc_reg, alt_reg, up_reg, pg_reg;
    logic [1:0]  sel_reg;
    logic [6:0]  prec_reg;
    logic [6:0]  w_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] total_reg;
    logic [LW-1:0] k_reg;
    logic          zp_done_reg;
    logic [23:0]   tail_reg;
    logic [1:0]    tail_n_reg;

    // Character buffer
    logic [7:0] buf_mem [CAP];
    logic [7:0] rd_reg;

    logic        hex;
    logic        oct;
    logic [79:0] val_adj;
    logic [79:0] val_rest;
    logic [3:0]  dig;
    logic [7:0]  dig_ch;
    logic        room;
    logic        pad_prec, pad_zero, pad_spc;
    logic [7:0]  pad_ch;
    logic [LW-1:0] len_trim;
    logic [LW-1:0] len_fin;
    logic [LW-1:0] total_fin;
    logic [23:0] tail_next;
    logic [7:0]  sgn_ch;
    logic        sgn_on;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic [LW-1:0] k_next;
    logic [LW-1:0] rd_idx;
    logic        x_on;
    logic [LW-1:0] tn;
    logic        emit_body;

    assign hex  = (sel_reg != itaf_pkg::SEL_OCT) && (sel_reg != itaf_pkg::SEL_DEC);
    assign oct  = (sel_reg == itaf_pkg::SEL_OCT);
    assign room = (len_reg < CAP_L);

    // Shift-and-add-3 correction of every BCD digit before the next shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            val_adj[4*i +: 4] = (val_reg[4*i +: 4] >= 4'd5) ?
                                (val_reg[4*i +: 4] + 4'd3) : val_reg[4*i +: 4];
        end
    end

    // Lowest digit and what remains once it is taken
    assign dig      = oct ? {1'b0, val_reg[2:0]} : val_reg[3:0];
    assign val_rest = oct ? (val_reg >> 3) : (val_reg >> 4);

    assign dig_ch = (dig < 4'd10) ? (itaf_pkg::CH_ZERO + 8'(dig)) :
                    ((up_reg ? itaf_pkg::CH_UA : itaf_pkg::CH_LA) + 8'(dig - 4'd10));

    // Padding classes, in the order the buffer builds them
    assign pad_prec = (7'(len_reg) < prec_reg);
    assign pad_zero = zp_reg && (7'(len_reg) < w_reg);
    assign pad_spc  = (7'(len_reg) < w_reg);
    assign pad_ch   = (pad_prec || (pad_zero && !zp_done_reg)) ? itaf_pkg::CH_ZERO
                                                                : itaf_pkg::CH_SPACE;

    // Prefix room taken from exact padding
    always_comb
    begin
        len_trim = len_reg;
        if (!pg_reg && (len_reg != '0) &&
            ((7'(len_reg) == prec_reg) || (7'(len_reg) == w_reg)))
        begin
            len_trim = len_reg - 1'b1;
            if ((len_trim != '0) && hex)
            begin
                len_trim = len_trim - 1'b1;
            end
        end
    end

    assign sgn_on = neg_reg || plus_reg || spc_reg;
    assign sgn_ch = neg_reg ? itaf_pkg::CH_MINUS :
                    plus_reg ? itaf_pkg::CH_PLUS : itaf_pkg::CH_SPACE;

    // Sign stage pushes prefix x, prefix 0 and sign in one go; the tail
    // keeps them in output order, leftmost in the low byte
    always_comb
    begin
        len_fin   = len_reg;
        tail_next = {3{itaf_pkg::CH_SPACE}};
        x_on      = cmd.push_x && room;
        if (x_on)
        begin
            len_fin   = len_fin + 1'b1;
            tail_next = {tail_next[15:0], (up_reg ? itaf_pkg::CH_UX : itaf_pkg::CH_LX)};
        end
        if (cmd.push_0 && (len_fin < CAP_L))
        begin
            len_fin   = len_fin + 1'b1;
            tail_next = {tail_next[15:0], itaf_pkg::CH_ZERO};
        end
        if (sgn_on && (len_fin < CAP_L))
        begin
            len_fin   = len_fin + 1'b1;
            tail_next = {tail_next[15:0], sgn_ch};
        end
        total_fin = len_fin;
        if (lj_reg && (7'(len_fin) < w_reg))
        begin
            total_fin = (w_reg < 7'(CAP_L)) ? LW'(w_reg) : CAP_L;
        end
    end

    // Single-write buffer port for digits and padding
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = pad_ch;
        if (cmd.push_dig)
        begin
            wr_en   = 1'b1;
            wr_data = dig_ch;
        end
        else if (cmd.push_pad)
        begin
            wr_en = 1'b1;
        end
    end
    assign wr_addr = len_reg[AW-1:0];

    // Word held at emit index, read one step ahead
    assign k_next = cmd.emit_adv ? (k_reg + 1'b1) : k_reg;
    assign rd_idx = len_reg - 1'b1 - k_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr] <= wr_data;
        end
        rd_reg <= buf_mem[rd_idx[AW-1:0]];
    end

    // Control registers of the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            k_reg       <= '0;
            total_reg   <= '0;
            bit_reg     <= '0;
            zp_done_reg <= 1'b0;
            tail_n_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                len_reg     <= '0;
                k_reg       <= '0;
                bit_reg     <= (base_sel == itaf_pkg::SEL_DEC) ? 7'd64 : 7'd0;
                zp_done_reg <= 1'b0;
                tail_n_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                bit_reg <= bit_reg - 1'b1;
            end
            else if (cmd.push_dig)
            begin
                len_reg <= len_reg + 1'b1;
            end
            else if (cmd.push_pad)
            begin
                len_reg <= len_reg + 1'b1;
                if (!pad_prec && !pad_zero)
                begin
                    zp_done_reg <= 1'b1;
                end
            end
            else if (cmd.alt_trim)
            begin
                len_reg <= len_trim;
            end
            else if (cmd.push_sgn)
            begin
                len_reg    <= len_fin;
                total_reg  <= total_fin;
                tail_n_reg <= 2'(len_fin - len_reg);
            end
            else if (cmd.emit_adv)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Payload registers of the item and the digit source
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg  <= magnitude;
            val_reg  <= (base_sel == itaf_pkg::SEL_DEC) ? 80'd0 : {16'd0, magnitude};
            zero_reg <= (magnitude == 64'd0);
            neg_reg  <= is_negative;
            sel_reg  <= base_sel;
            prec_reg <= min_digits;
            zp_reg   <= zero_pad;
            lj_reg   <= left_justify;
            plus_reg <= plus_sign;
            spc_reg  <= space_sign;
            alt_reg  <= alt_form && (magnitude != 64'd0);
            up_reg   <= upper_case;
            pg_reg   <= precision_given;
            if (!left_justify && (field_width != 7'd0) && zero_pad &&
                (is_negative || plus_sign || space_sign))
            begin
                w_reg <= field_width - 7'd1;
            end
            else
            begin
                w_reg <= field_width;
            end
        end
        else if (cmd.div_step)
        begin
            val_reg <= {val_adj[78:0], bin_reg[63]};
            bin_reg <= {bin_reg[62:0], 1'b0};
        end
        else if (cmd.push_dig)
        begin
            val_reg <= val_rest;
        end
        else if (cmd.push_sgn)
        begin
            tail_reg <= tail_next;
        end
    end

    // Status
    assign sts.div_done  = (bit_reg == 7'd0);
    assign sts.more_dig  = (val_rest != 80'd0) && ((len_reg + 1'b1) < CAP_L);
    assign sts.skip_dig  = pg_reg && zero_reg;
    assign sts.pad_more  = !lj_reg && room && (pad_prec || pad_zero || pad_spc);
    assign sts.alt_on    = alt_reg;
    assign sts.x_room    = hex;
    assign sts.emit_last = (total_reg == '0) || ((k_reg + 1'b1) == total_reg);

    // Output selection: tail, then buffer body, then right padding (NUL for an empty field)
    assign tn = LW'(tail_n_reg);
    always_comb
    begin
        char_code = itaf_pkg::CH_SPACE;
        if (total_reg == '0)
        begin
            char_code = 8'd0;
        end
        else if (k_reg >= len_reg)
        begin
            char_code = itaf_pkg::CH_SPACE;
        end
        else if (k_reg < tn)
        begin
            case (k_reg[1:0])
                2'd0:    char_code = tail_reg[7:0];
                2'd1:    char_code = tail_reg[15:8];
                default: char_code = tail_reg[23:16];
            endcase
        end
        else
        begin
            char_code = rd_reg;
        end
    end

    assign last_char   = sts.emit_last;
    assign empty_field = (total_reg == '0);
    assign emit_body   = cmd.emit_adv && (total_reg != '0);

    `ITAF_ASSERT_IMP(a_len_cap, clk, rst_n, 1'b1, len_reg <= CAP_L, "length beyond cap")
    `ITAF_ASSERT_IMP(a_total_cap, clk, rst_n, cmd.emit_adv, total_reg <= CAP_L, "total beyond cap")
    `ITAF_ASSERT_IMP(a_emit_range, clk, rst_n, emit_body, k_reg < total_reg, "emit past end")

endmodule
